### design/vic_pkg.sv
package vic_pkg;

    localparam int COORD_W   = 10;
    localparam int IDX_W     = 30;
    localparam int DIM_W     = 11;
    localparam int PLANE_W   = 2 * DIM_W;
    localparam int TOTAL_W   = DIM_W + PLANE_W;
    localparam int CFG_IDX_W = 2;

    localparam logic OP_FWD = 1'b0;
    localparam logic OP_REV = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_DIM_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z = 2'd2;

    // Front-end result handed to the divider chain
    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] lin;
        logic [IDX_W-1:0] idx;
        logic             flag;
    } vic_fwd_t;

    // Fields that ride alongside the divider stages
    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] idx;
        logic             flag;
    } vic_side_t;

    typedef struct packed {
        vic_side_t        side;
        logic [IDX_W-1:0] quo_x;
    } vic_side2_t;

endpackage

### design/vic_req_if.sv
interface vic_req_if import vic_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               operation;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
    logic [IDX_W-1:0]   linear_index;

    modport source (
        output valid, operation, coord_x, coord_y, coord_z, linear_index,
        input  ready
    );
    modport sink (
        input  valid, operation, coord_x, coord_y, coord_z, linear_index,
        output ready
    );
endinterface

### design/vic_rsp_if.sv
interface vic_rsp_if import vic_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   out_index;
    logic [IDX_W-1:0]   out_x;
    logic [COORD_W-1:0] out_y;
    logic [COORD_W-1:0] out_z;
    logic               out_of_grid;

    modport source (
        output valid, out_index, out_x, out_y, out_z, out_of_grid,
        input  ready
    );
    modport sink (
        input  valid, out_index, out_x, out_y, out_z, out_of_grid,
        output ready
    );
endinterface

### design/vic_fwd.sv
module vic_fwd import vic_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_vld,
    input  logic               operation,
    input  logic [COORD_W-1:0] coord_x,
    input  logic [COORD_W-1:0] coord_y,
    input  logic [COORD_W-1:0] coord_z,
    input  logic [IDX_W-1:0]   linear_index,
    input  logic [PLANE_W-1:0] plane,
    input  logic [TOTAL_W-1:0] total,
    input  logic [DIM_W-1:0]   nz,
    output logic               out_vld,
    output vic_fwd_t           out_data
);

    localparam int P1_W = COORD_W + PLANE_W;
    localparam int P2_W = COORD_W + DIM_W;

    logic               s0_vld_reg;
    logic               s0_op_reg;
    logic [COORD_W-1:0] s0_x_reg;
    logic [COORD_W-1:0] s0_y_reg;
    logic [COORD_W-1:0] s0_z_reg;
    logic [IDX_W-1:0]   s0_lin_reg;

    logic               s1_vld_reg;
    logic               s1_op_reg;
    logic [IDX_W-1:0]   s1_lin_reg;
    logic [P1_W-1:0]    s1_p1_reg;
    logic [P2_W-1:0]    s1_p2_reg;
    logic [COORD_W-1:0] s1_z_reg;

    logic               s2_vld_reg;
    vic_fwd_t           s2_data_reg;
    vic_fwd_t           s2_data_next;
    logic [TOTAL_W-1:0] sum;

    always_comb
    begin
        sum = TOTAL_W'(s1_p1_reg) + TOTAL_W'(s1_p2_reg) + TOTAL_W'(s1_z_reg);
        s2_data_next.op  = s1_op_reg;
        s2_data_next.lin = s1_lin_reg;
        s2_data_next.idx = sum[IDX_W-1:0];
        if (s1_op_reg == OP_REV)
        begin
            s2_data_next.flag = (TOTAL_W'(s1_lin_reg) >= total);
        end
        else
        begin
            s2_data_next.flag = (sum >= total);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_vld_reg <= in_vld;
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_op_reg   <= operation;
            s0_x_reg    <= coord_x;
            s0_y_reg    <= coord_y;
            s0_z_reg    <= coord_z;
            s0_lin_reg  <= linear_index;
            s1_op_reg   <= s0_op_reg;
            s1_lin_reg  <= s0_lin_reg;
            s1_p1_reg   <= P1_W'(s0_x_reg) * P1_W'(plane);
            s1_p2_reg   <= P2_W'(s0_y_reg) * P2_W'(nz);
            s1_z_reg    <= s0_z_reg;
            s2_data_reg <= s2_data_next;
        end
    end

    assign out_vld  = s2_vld_reg;
    assign out_data = s2_data_reg;

endmodule

### design/vic_div_pipe.sv
module vic_div_pipe
#(
    parameter int N = 30,
    parameter int D = 22,
    parameter int S = 5,
    parameter int W = 1
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         adv,
    input  logic         in_vld,
    input  logic [N-1:0] in_num,
    input  logic [D-1:0] in_rem,
    input  logic [D-1:0] div,
    input  logic [W-1:0] in_side,
    output logic         out_vld,
    output logic [N-1:0] out_quo,
    output logic [D-1:0] out_rem,
    output logic [W-1:0] out_side
);

    localparam int NS = (N + S - 1) / S;

    logic [NS-1:0] vld_reg;
    logic [N-1:0]  num_reg  [NS];
    logic [D-1:0]  rem_reg  [NS];
    logic [W-1:0]  side_reg [NS];

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic         prev_vld;
        logic [N-1:0] prev_num;
        logic [D-1:0] prev_rem;
        logic [W-1:0] prev_side;
        logic [N-1:0] num_next;
        logic [D-1:0] rem_next;

        if (k == 0)
        begin : g_first
            assign prev_vld  = in_vld;
            assign prev_num  = in_num;
            assign prev_rem  = in_rem;
            assign prev_side = in_side;
        end
        else
        begin : g_rest
            assign prev_vld  = vld_reg[k-1];
            assign prev_num  = num_reg[k-1];
            assign prev_rem  = rem_reg[k-1];
            assign prev_side = side_reg[k-1];
        end

        // Restoring division, one quotient bit per step, MSB first
        always_comb
        begin
            logic [D:0]   r;
            logic [N-1:0] q;
            logic [D-1:0] rm;
            r  = '0;
            q  = prev_num;
            rm = prev_rem;
            for (int j = 0; j < S; j++)
            begin
                if (k * S + j < N)
                begin
                    r = {rm, q[N-1]};
                    q = {q[N-2:0], 1'b0};
                    if (r >= {1'b0, div})
                    begin
                        r    = r - {1'b0, div};
                        q[0] = 1'b1;
                    end
                    rm = r[D-1:0];
                end
            end
            num_next = q;
            rem_next = rm;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k] <= prev_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                num_reg[k]  <= num_next;
                rem_reg[k]  <= rem_next;
                side_reg[k] <= prev_side;
            end
        end
    end

    assign out_vld  = vld_reg[NS-1];
    assign out_quo  = num_reg[NS-1];
    assign out_rem  = rem_reg[NS-1];
    assign out_side = side_reg[NS-1];

endmodule

### design/voxel_index_convert_core.sv
// Voxel index converter: row-major 3D coordinates <-> linear index.
// Channel req carries one conversion per transfer (operation selects forward
// or reverse); channel rsp returns exactly one result per request, in order.
// Grid sizes are written through cfg_we/cfg_index/cfg_data while the block is
// idle (a rule for the user; the block does not enforce it); a zero size acts
// as 1 and sizes clamp at 2**DIM_BITS. From the request transfer to rsp.valid
// there are thirteen register stages, the first of which captures the request
// at the transfer edge: a three-stage front end (input register, multipliers,
// add and compare), the quotient by the plane size in six stages of five bits,
// the quotient by dim_z in three stages of four bits, and the output register.
// Throughput is one transfer per cycle unless the receiver stalls; the whole
// pipeline advances together. When the receiver stalls with a result waiting,
// every stage holds and req.ready drops in the same cycle, so nothing is lost
// or repeated. Reset empties the pipeline and sets every grid size to 1.
module voxel_index_convert_core import vic_pkg::*;
#(
    parameter int DIM_BITS = 10
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    vic_req_if.sink              req,
    vic_rsp_if.source            rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    localparam longint unsigned LIM = 64'd1 << DIM_BITS;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (64'(v) > LIM)
        begin
            r = DIM_W'(LIM);
        end
        return r;
    endfunction

    logic [DIM_W-1:0]   dim_x_reg;
    logic [DIM_W-1:0]   dim_y_reg;
    logic [DIM_W-1:0]   dim_z_reg;
    logic [DIM_W-1:0]   nx;
    logic [DIM_W-1:0]   ny;
    logic [DIM_W-1:0]   nz;
    logic [PLANE_W-1:0] plane_reg;
    logic [TOTAL_W-1:0] total_reg;

    logic               adv;
    logic               f_vld;
    vic_fwd_t           f_data;
    vic_side_t          f_side;

    logic               d1_vld;
    logic [IDX_W-1:0]   d1_quo;
    logic [PLANE_W-1:0] d1_rem;
    vic_side_t          d1_side;
    vic_side2_t         d1_side2;

    logic               d2_vld;
    logic [DIM_W-1:0]   d2_quo;
    logic [DIM_W-1:0]   d2_rem;
    vic_side2_t         d2_side2;

    logic               out_vld_reg;
    logic [IDX_W-1:0]   out_index_reg;
    logic [IDX_W-1:0]   out_x_reg;
    logic [COORD_W-1:0] out_y_reg;
    logic [COORD_W-1:0] out_z_reg;
    logic               out_flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_x_reg <= DIM_W'(1);
            dim_y_reg <= DIM_W'(1);
            dim_z_reg <= DIM_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DIM_X: dim_x_reg <= cfg_data;
                CFG_DIM_Y: dim_y_reg <= cfg_data;
                CFG_DIM_Z: dim_z_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    assign nx = eff_dim(dim_x_reg);
    assign ny = eff_dim(dim_y_reg);
    assign nz = eff_dim(dim_z_reg);

    // Grid products are registered: plane_reg from ny*nz, then total_reg from nx and plane_reg
    always_ff @(posedge clk)
    begin
        plane_reg <= PLANE_W'(ny) * PLANE_W'(nz);
        total_reg <= TOTAL_W'(nx) * TOTAL_W'(plane_reg);
    end

    assign adv       = !out_vld_reg || rsp.ready;
    assign req.ready = adv;

    vic_fwd u_fwd (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_vld       (req.valid),
        .operation    (req.operation),
        .coord_x      (req.coord_x),
        .coord_y      (req.coord_y),
        .coord_z      (req.coord_z),
        .linear_index (req.linear_index),
        .plane        (plane_reg),
        .total        (total_reg),
        .nz           (nz),
        .out_vld      (f_vld),
        .out_data     (f_data)
    );

    assign f_side.op   = f_data.op;
    assign f_side.idx  = f_data.idx;
    assign f_side.flag = f_data.flag;

    vic_div_pipe #(
        .N (IDX_W),
        .D (PLANE_W),
        .S (5),
        .W ($bits(vic_side_t))
    ) u_div_plane (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (f_vld),
        .in_num   (f_data.lin),
        .in_rem   ('0),
        .div      (plane_reg),
        .in_side  (f_side),
        .out_vld  (d1_vld),
        .out_quo  (d1_quo),
        .out_rem  (d1_rem),
        .out_side (d1_side)
    );

    assign d1_side2.side  = d1_side;
    assign d1_side2.quo_x = d1_quo;

    // Remainder < ny*nz, so its upper half is already below nz
    vic_div_pipe #(
        .N (DIM_W),
        .D (DIM_W),
        .S (4),
        .W ($bits(vic_side2_t))
    ) u_div_row (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (d1_vld),
        .in_num   (d1_rem[DIM_W-1:0]),
        .in_rem   (d1_rem[PLANE_W-1:DIM_W]),
        .div      (nz),
        .in_side  (d1_side2),
        .out_vld  (d2_vld),
        .out_quo  (d2_quo),
        .out_rem  (d2_rem),
        .out_side (d2_side2)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= d2_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_flag_reg <= d2_side2.side.flag;
            if (d2_side2.side.op == OP_REV)
            begin
                out_index_reg <= '0;
                out_x_reg     <= d2_side2.quo_x;
                out_y_reg     <= d2_quo[COORD_W-1:0];
                out_z_reg     <= d2_rem[COORD_W-1:0];
            end
            else
            begin
                out_index_reg <= d2_side2.side.flag ? '0 : d2_side2.side.idx;
                out_x_reg     <= '0;
                out_y_reg     <= '0;
                out_z_reg     <= '0;
            end
        end
    end

    assign rsp.valid       = out_vld_reg;
    assign rsp.out_index   = out_index_reg;
    assign rsp.out_x       = out_x_reg;
    assign rsp.out_y       = out_y_reg;
    assign rsp.out_z       = out_z_reg;
    assign rsp.out_of_grid = out_flag_reg;

endmodule

### dv/tb_voxel_index_convert_core.sv
module tb_voxel_index_convert_core;
    timeunit 1ns;
    timeprecision 1ps;

    import vic_pkg::*;

    localparam int LATENCY = 13;
    localparam int N_RAND  = 800;

    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [IDX_W-1:0]   lin;
    } conv_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]   index;
        logic [IDX_W-1:0]   x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               oog;
    } conv_rsp_t;

    // Directed row: request, and a typed-in result when has_exp is set
    typedef struct packed {
        conv_req_t rq;
        logic      has_exp;
        conv_rsp_t ex;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0] cfg_data = '0;

    vic_req_if req ();
    vic_rsp_if rsp ();

    voxel_index_convert_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .rsp       (rsp.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    logic [DIM_W-1:0] grid_x = 1, grid_y = 1, grid_z = 1;
    conv_rsp_t pending_results[$];
    int n_mismatch = 0;
    int n_checked = 0;
    int n_fwd = 0, n_rev = 0, n_oog = 0;
    bit stim_done = 1'b0;

    function automatic longint unsigned clamp_dim(logic [DIM_W-1:0] v);
        longint unsigned lim;
        lim = 64'd1 << 10;
        if (v == 0)
            return 64'd1;
        if (64'(v) > lim)
            return lim;
        return 64'(v);
    endfunction

    function automatic conv_rsp_t convert_voxel(conv_req_t rq);
        longint unsigned nx, ny, nz, plane, total, lin, qx, rem, qy, qz;
        conv_rsp_t r;
        nx = clamp_dim(grid_x);
        ny = clamp_dim(grid_y);
        nz = clamp_dim(grid_z);
        plane = ny * nz;
        total = nx * plane;
        r = '0;
        if (rq.op == OP_FWD)
        begin
            lin = 64'(rq.x) * plane + 64'(rq.y) * nz + 64'(rq.z);
            if (lin >= total)
                r.oog = 1'b1;
            else
                r.index = lin[IDX_W-1:0];
        end
        else
        begin
            lin = 64'(rq.lin);
            qx = lin / plane;
            rem = lin - qx * plane;
            qy = rem / nz;
            qz = rem - qy * nz;
            r.x = qx[IDX_W-1:0];
            r.y = qy[COORD_W-1:0];
            r.z = qz[COORD_W-1:0];
            r.oog = (lin >= total);
        end
        return r;
    endfunction

    task automatic write_dim(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DIM_X: grid_x = val;
            CFG_DIM_Y: grid_y = val;
            CFG_DIM_Z: grid_z = val;
            default: ;
        endcase
    endtask

    task automatic set_grid(logic [DIM_W-1:0] a, logic [DIM_W-1:0] b, logic [DIM_W-1:0] c);
        write_dim(CFG_DIM_X, a);
        write_dim(CFG_DIM_Y, b);
        write_dim(CFG_DIM_Z, c);
    endtask

    task automatic drain();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    // Drop valid for a random gap, then hold the request until the transfer
    task automatic send_conv(conv_req_t rq, bit has_exp, conv_rsp_t ex);
        int gap;
        conv_rsp_t pr;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid <= 1'b1;
        req.operation <= rq.op;
        req.coord_x <= rq.x;
        req.coord_y <= rq.y;
        req.coord_z <= rq.z;
        req.linear_index <= rq.lin;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pr = convert_voxel(rq);
        if (has_exp && pr !== ex)
            $display("directed row disagrees with predictor: %h vs %h", ex, pr);
        pending_results.push_back(has_exp ? ex : pr);
        if (rq.op == OP_FWD) n_fwd++; else n_rev++;
        if (pr.oog) n_oog++;
        @(negedge clk);
    endtask

    task automatic idle_req();
        req.valid <= 1'b0;
    endtask

    function automatic conv_req_t rand_req();
        conv_req_t rq;
        longint unsigned total;
        rq.op = 1'($urandom_range(0, 1));
        rq.x = COORD_W'($urandom);
        rq.y = COORD_W'($urandom);
        rq.z = COORD_W'($urandom);
        rq.lin = IDX_W'($urandom);
        total = clamp_dim(grid_x) * clamp_dim(grid_y) * clamp_dim(grid_z);
        // Mostly in-grid values so both sides of the bound get traffic
        if ($urandom_range(0, 3) != 0)
        begin
            rq.x = COORD_W'($urandom_range(0, 32'(clamp_dim(grid_x) - 1)));
            rq.y = COORD_W'($urandom_range(0, 32'(clamp_dim(grid_y) - 1)));
            rq.z = COORD_W'($urandom_range(0, 32'(clamp_dim(grid_z) - 1)));
            rq.lin = IDX_W'({$urandom, $urandom} % total);
        end
        else if ($urandom_range(0, 1) == 0)
            rq.lin = IDX_W'(total);
        return rq;
    endfunction

    // Response side: random wait per result, sample at the rising edge
    initial
    begin
        conv_rsp_t got, want;
        int stall;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 7);
            if ($urandom_range(0, 3) == 0)
                stall = 0;
            if (stall != 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (!rsp.valid)
                @(posedge clk);
            got = '{rsp.out_index, rsp.out_x, rsp.out_y, rsp.out_z, rsp.out_of_grid};
            if (pending_results.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = pending_results.pop_front();
                n_checked++;
                if (got !== want)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display({"mismatch: exp idx=%0d x=%0d y=%0d z=%0d oog=%0b",
                                  " got idx=%0d x=%0d y=%0d z=%0d oog=%0b"},
                            want.index, want.x, want.y, want.z, want.oog,
                            got.index, got.x, got.y, got.z, got.oog);
                end
            end
            @(negedge clk);
        end
    end

    initial
    begin
        #3000000;
        $display("voxel_index_convert_core regression: fail");
        $finish;
    end

    dir_row_t dir_rows[] = '{
        // after reset: 1x1x1 grid
        '{'{OP_FWD, 10'd0, 10'd0, 10'd0, 30'd0}, 1'b1, '{30'd0, 30'd0, 10'd0, 10'd0, 1'b0}},
        '{'{OP_FWD, 10'd1, 10'd0, 10'd0, 30'd0}, 1'b1, '{30'd0, 30'd0, 10'd0, 10'd0, 1'b1}},
        '{'{OP_FWD, 10'h3FF, 10'h3FF, 10'h3FF, 30'd0}, 1'b1,
          '{30'd0, 30'd0, 10'd0, 10'd0, 1'b1}},
        '{'{OP_REV, 10'd0, 10'd0, 10'd0, 30'd0}, 1'b1, '{30'd0, 30'd0, 10'd0, 10'd0, 1'b0}},
        '{'{OP_REV, 10'd0, 10'd0, 10'd0, 30'h3FFFFFFF}, 1'b1,
          '{30'd0, 30'h3FFFFFFF, 10'd0, 10'd0, 1'b1}},
        '{'{OP_REV, 10'h155, 10'h2AA, 10'h155, 30'd1}, 1'b1,
          '{30'd0, 30'd1, 10'd0, 10'd0, 1'b1}}
    };

    dir_row_t big_rows[] = '{
        '{'{OP_FWD, 10'h3FF, 10'h3FF, 10'h3FF, 30'd0}, 1'b1,
          '{30'h3FFFFFFF, 30'd0, 10'd0, 10'd0, 1'b0}},
        '{'{OP_REV, 10'd0, 10'd0, 10'd0, 30'h3FFFFFFF}, 1'b1,
          '{30'd0, 30'h3FF, 10'h3FF, 10'h3FF, 1'b0}},
        '{'{OP_FWD, 10'h2AA, 10'h155, 10'h2AA, 30'd0}, 1'b0, '0},
        '{'{OP_REV, 10'd0, 10'd0, 10'd0, 30'h15555555}, 1'b0, '0},
        '{'{OP_REV, 10'd0, 10'd0, 10'd0, 30'h2AAAAAAA}, 1'b0, '0},
        '{'{OP_FWD, 10'd0, 10'd0, 10'd1, 30'd0}, 1'b0, '0}
    };

    initial
    begin
        logic [DIM_W-1:0] cfgs[8][3];
        int k;
        req.valid = 1'b0;
        req.operation = OP_FWD;
        req.coord_x = '0;
        req.coord_y = '0;
        req.coord_z = '0;
        req.linear_index = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
            send_conv(dir_rows[i].rq, dir_rows[i].has_exp, dir_rows[i].ex);
        idle_req();
        drain();

        // largest legal grid, then oversized and zero sizes that clamp
        set_grid(11'd1024, 11'd1024, 11'd1024);
        foreach (big_rows[i])
            send_conv(big_rows[i].rq, big_rows[i].has_exp, big_rows[i].ex);
        idle_req();
        drain();
        set_grid(11'h7FF, 11'd0, 11'd1500);
        foreach (big_rows[i])
            send_conv(big_rows[i].rq, 1'b0, '0);
        idle_req();
        drain();
        write_dim(2'd3, 11'h7FF); // unmapped index, must be ignored
        send_conv(big_rows[0].rq, 1'b0, '0);
        idle_req();
        drain();

        cfgs = '{'{11'd1, 11'd1, 11'd1}, '{11'd7, 11'd5, 11'd3},
                 '{11'd1024, 11'd1024, 11'd1024}, '{11'd0, 11'd0, 11'd0},
                 '{11'd2000, 11'd1, 11'd33}, '{11'd17, 11'd1023, 11'd2},
                 '{11'd1, 11'd1, 11'd1024}, '{11'd0, 11'd0, 11'd0}};
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 7)
                set_grid(DIM_W'($urandom), DIM_W'($urandom), DIM_W'($urandom));
            else
                set_grid(cfgs[ph][0], cfgs[ph][1], cfgs[ph][2]);
            for (k = 0; k < N_RAND / 8; k++)
                send_conv(rand_req(), 1'b0, '0);
            idle_req();
            drain();
        end
        stim_done = 1'b1;

        $display("checked %0d results: %0d forward, %0d reverse, %0d out of grid",
            n_checked, n_fwd, n_rev, n_oog);
        $display("grids from 1x1x1 to 1024^3, with zero and oversized sizes");
        if (n_mismatch == 0 && pending_results.size() == 0)
            $display("voxel_index_convert_core regression: pass");
        else
            $display("voxel_index_convert_core regression: fail");
        $finish;
    end

endmodule
